### rtl/gspb_pkg.sv
`default_nettype none
package gspb_pkg;

   localparam int MAX_STOPS = 16;
   localparam int ADDR_W    = $clog2(MAX_STOPS);
   localparam int COUNT_W   = $clog2(MAX_STOPS + 1);

   localparam logic [3:0] ENTRY_LAST = 4'd15;
   localparam logic [7:0] FULL_SCALE = 8'd255;

   typedef struct packed {
      logic [7:0] pos;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } stop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INSERT,
      ST_INSERT_ZERO,
      ST_READ,
      ST_EVAL,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

endpackage
`default_nettype wire

### rtl/gradient_stop_palette_builder_unit.sv
`default_nettype none
// Gradient palette builder. Stops arrive one beat at a time and are kept in a 16-entry
// synchronous memory in position order: each stop is placed by an insertion pass that
// shifts larger entries up one per cycle. Stops beyond sixteen are dropped. The beat
// with req_last_stop starts the build: each of the sixteen entries scans the memory
// (up to n+2 reads for n stops held); an entry inside a segment then runs a restoring
// divider for the progress value, a multiply step and a scaling step. Each entry is
// held on rsp until taken. No input beat is taken during insertion or a build.
// csr_write_data selects circular wrapping (1) or clamped linear sampling (0).
module gradient_stop_palette_builder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_stop_position,
   input  wire logic [7:0] req_stop_red,
   input  wire logic [7:0] req_stop_green,
   input  wire logic [7:0] req_stop_blue,
   input  wire logic       req_last_stop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_entry_number,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue,
   output logic            rsp_last_entry,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data
);

   localparam int AW = gspb_pkg::ADDR_W;
   localparam int CW = gspb_pkg::COUNT_W;

   gspb_pkg::state_type state_ff, state_in;

   gspb_pkg::stop_type mem [gspb_pkg::MAX_STOPS];
   gspb_pkg::stop_type rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   gspb_pkg::stop_type wr_data;

   logic               mode_ff;
   logic [CW-1:0]      loaded_ff;
   gspb_pkg::stop_type new_ff;
   logic               new_last_ff;
   logic [AW-1:0]      k_ff;
   logic [3:0]         entry_ff;
   logic [CW-1:0]      step_ff;
   gspb_pkg::stop_type last_ff, prev_ff, left_ff, right_ff, color_ff;
   logic [7:0]         span_ff, rem_ff, lo_ff, quo_ff;
   logic [2:0]         cnt_ff;
   logic [15:0]        acc_r_ff, acc_g_ff, acc_b_ff;

   gspb_pkg::stop_type req_stop;
   logic               req_accept;
   logic               full;
   logic [7:0]         target;
   logic [CW-1:0]      step_m1;
   logic [7:0]         span_w, dist_w;
   logic [15:0]        num_w;
   logic               seg_hit;
   logic               ev_done, ev_div;
   gspb_pkg::stop_type ev_color;
   logic               shift_up;
   logic [8:0]         trial;
   logic               trial_ge;
   logic [7:0]         prog_inv;
   logic [15:0]        scale_r, scale_g, scale_b;

   assign req_stop   = '{pos: req_stop_position, red: req_stop_red,
                         green: req_stop_green, blue: req_stop_blue};
   assign req_accept = req_valid && !req_stall;
   assign full       = (loaded_ff >= CW'(gspb_pkg::MAX_STOPS));
   assign target     = (entry_ff == gspb_pkg::ENTRY_LAST) ? gspb_pkg::FULL_SCALE
                                                          : {entry_ff, 4'b0000};
   assign step_m1    = step_ff - CW'(1);
   assign shift_up   = (rd_data_ff.pos > new_ff.pos);

   // segment from prev to current read, positions taken mod 256
   assign span_w  = rd_data_ff.pos - prev_ff.pos;
   assign dist_w  = target - prev_ff.pos;
   assign seg_hit = (dist_w <= span_w);
   assign num_w   = {dist_w, 8'h00} - {8'h00, dist_w};

   always_comb begin
      ev_done  = 1'b0;
      ev_div   = 1'b0;
      ev_color = rd_data_ff;
      if (step_ff == '0) begin
         ev_done = (loaded_ff == CW'(1));
      end else if (step_ff == CW'(1)) begin
         if (!mode_ff) begin
            if (target <= rd_data_ff.pos) begin
               ev_done = 1'b1;
            end else if (target >= last_ff.pos) begin
               ev_done  = 1'b1;
               ev_color = last_ff;
            end
         end
      end else if (seg_hit) begin
         if (span_w == '0) begin
            ev_done = 1'b1;
         end else begin
            ev_div = 1'b1;
         end
      end else if (step_ff == loaded_ff + CW'(1)) begin
         ev_done  = 1'b1;
         ev_color = last_ff;
      end
   end

   assign trial    = {rem_ff, lo_ff[7]};
   assign trial_ge = (trial >= {1'b0, span_ff});
   assign prog_inv = gspb_pkg::FULL_SCALE - quo_ff;

   // x/255 for x below 2^16
   assign scale_r = acc_r_ff + 16'd1 + {8'h00, acc_r_ff[15:8]};
   assign scale_g = acc_g_ff + 16'd1 + {8'h00, acc_g_ff[15:8]};
   assign scale_b = acc_b_ff + 16'd1 + {8'h00, acc_b_ff[15:8]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gspb_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (!full && loaded_ff != '0) begin
                  state_in = gspb_pkg::ST_INSERT;
               end else if (req_last_stop) begin
                  state_in = gspb_pkg::ST_READ;
               end
            end
         end
         gspb_pkg::ST_INSERT: begin
            if (shift_up) begin
               if (k_ff == '0) begin
                  state_in = gspb_pkg::ST_INSERT_ZERO;
               end
            end else begin
               state_in = new_last_ff ? gspb_pkg::ST_READ : gspb_pkg::ST_IDLE;
            end
         end
         gspb_pkg::ST_INSERT_ZERO: begin
            state_in = new_last_ff ? gspb_pkg::ST_READ : gspb_pkg::ST_IDLE;
         end
         gspb_pkg::ST_READ: state_in = gspb_pkg::ST_EVAL;
         gspb_pkg::ST_EVAL: begin
            if (ev_done) begin
               state_in = gspb_pkg::ST_OUTPUT;
            end else if (ev_div) begin
               state_in = gspb_pkg::ST_DIVIDE;
            end else begin
               state_in = gspb_pkg::ST_READ;
            end
         end
         gspb_pkg::ST_DIVIDE: begin
            if (cnt_ff == 3'd7) begin
               state_in = gspb_pkg::ST_MULTIPLY;
            end
         end
         gspb_pkg::ST_MULTIPLY: state_in = gspb_pkg::ST_SCALE;
         gspb_pkg::ST_SCALE: state_in = gspb_pkg::ST_OUTPUT;
         gspb_pkg::ST_OUTPUT: begin
            if (!rsp_stall) begin
               state_in = (entry_ff == gspb_pkg::ENTRY_LAST) ? gspb_pkg::ST_IDLE
                                                             : gspb_pkg::ST_READ;
            end
         end
         default: state_in = gspb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != gspb_pkg::ST_IDLE);
      rsp_valid = (state_ff == gspb_pkg::ST_OUTPUT);
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = new_ff;
      unique case (state_ff)
         gspb_pkg::ST_IDLE: begin
            rd_addr = AW'(loaded_ff - CW'(1));
            if (req_accept && loaded_ff == '0) begin
               wr_en   = 1'b1;
               wr_data = req_stop;
            end
         end
         gspb_pkg::ST_INSERT: begin
            rd_addr = k_ff - AW'(1);
            wr_en   = 1'b1;
            wr_addr = k_ff + AW'(1);
            wr_data = shift_up ? rd_data_ff : new_ff;
         end
         gspb_pkg::ST_INSERT_ZERO: begin
            wr_en = 1'b1;
         end
         gspb_pkg::ST_READ: begin
            if (step_ff == '0) begin
               rd_addr = AW'(loaded_ff - CW'(1));
            end else if (step_m1 == loaded_ff) begin
               rd_addr = '0;
            end else begin
               rd_addr = AW'(step_m1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_entry_number = entry_ff;
   assign rsp_out_red      = color_ff.red;
   assign rsp_out_green    = color_ff.green;
   assign rsp_out_blue     = color_ff.blue;
   assign rsp_last_entry   = (entry_ff == gspb_pkg::ENTRY_LAST);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gspb_pkg::ST_IDLE;
         mode_ff   <= 1'b0;
         loaded_ff <= '0;
         entry_ff  <= '0;
         step_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         unique case (state_ff)
            gspb_pkg::ST_IDLE: begin
               entry_ff <= '0;
               step_ff  <= '0;
               if (req_accept && !full && loaded_ff == '0) begin
                  loaded_ff <= CW'(1);
               end
            end
            gspb_pkg::ST_INSERT: begin
               if (!shift_up) begin
                  loaded_ff <= loaded_ff + CW'(1);
               end
            end
            gspb_pkg::ST_INSERT_ZERO: begin
               loaded_ff <= loaded_ff + CW'(1);
            end
            gspb_pkg::ST_EVAL: begin
               if (!ev_done && !ev_div) begin
                  step_ff <= step_ff + CW'(1);
               end
            end
            gspb_pkg::ST_OUTPUT: begin
               if (!rsp_stall) begin
                  entry_ff <= entry_ff + 4'd1;
                  step_ff  <= '0;
                  if (entry_ff == gspb_pkg::ENTRY_LAST) begin
                     loaded_ff <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         gspb_pkg::ST_IDLE: begin
            if (req_accept) begin
               new_ff      <= req_stop;
               new_last_ff <= req_last_stop;
               k_ff        <= AW'(loaded_ff - CW'(1));
            end
         end
         gspb_pkg::ST_INSERT: begin
            k_ff <= k_ff - AW'(1);
         end
         gspb_pkg::ST_EVAL: begin
            if (step_ff == '0) begin
               last_ff <= rd_data_ff;
            end
            prev_ff  <= rd_data_ff;
            color_ff <= ev_color;
            left_ff  <= prev_ff;
            right_ff <= rd_data_ff;
            span_ff  <= span_w;
            rem_ff   <= num_w[15:8];
            lo_ff    <= num_w[7:0];
            quo_ff   <= '0;
            cnt_ff   <= '0;
         end
         gspb_pkg::ST_DIVIDE: begin
            rem_ff <= trial_ge ? 8'(trial - {1'b0, span_ff}) : trial[7:0];
            quo_ff <= {quo_ff[6:0], trial_ge};
            lo_ff  <= {lo_ff[6:0], 1'b0};
            cnt_ff <= cnt_ff + 3'd1;
         end
         gspb_pkg::ST_MULTIPLY: begin
            acc_r_ff <= left_ff.red * prog_inv + right_ff.red * quo_ff;
            acc_g_ff <= left_ff.green * prog_inv + right_ff.green * quo_ff;
            acc_b_ff <= left_ff.blue * prog_inv + right_ff.blue * quo_ff;
         end
         gspb_pkg::ST_SCALE: begin
            color_ff.red   <= scale_r[15:8];
            color_ff.green <= scale_g[15:8];
            color_ff.blue  <= scale_b[15:8];
         end
         default: ;
      endcase
   end

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CW'(gspb_pkg::MAX_STOPS))
      else $error("stop count above store depth");

   a_clear_after_build: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_entry) |=> (loaded_ff == '0))
      else $error("stop count not cleared after build");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gspb_pkg::ST_DIVIDE) |-> (span_ff != '0))
      else $error("divide with zero span");

   a_no_write_in_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gspb_pkg::ST_READ || state_ff == gspb_pkg::ST_EVAL) |-> !wr_en)
      else $error("store written during build");

endmodule
`default_nettype wire
